// ----- hdl/stereo_peak_meter_auto_gain_core_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the stereo peak meter
// Clocked concurrent assertion with asynchronous reset disable.
// ---------------------------------------------------------------------------
`ifndef STEREO_PEAK_METER_AUTO_GAIN_CORE_ASSERT_SVH
`define STEREO_PEAK_METER_AUTO_GAIN_CORE_ASSERT_SVH

// Check prop on every rising edge of ck while rn is high.
`define SPMAG_ASSERT(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Check prop on the local clk, held off while arst_n is low.
`define SPMAG_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`endif

// ----- hdl/spmag_pkg.sv -----
// ---------------------------------------------------------------------------
// spmag_pkg
// Types, codes and reset values shared by the stereo peak meter.
// ---------------------------------------------------------------------------
package spmag_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int CLIP_BITS   = 16;
	localparam int CMP_BITS    = (SAMPLE_BITS > CLIP_BITS) ? SAMPLE_BITS : CLIP_BITS;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [SAMPLE_BITS-1:0]        mag_t;
	typedef logic [6:0]                    gain_t;
	typedef logic [7:0]                    count_t;

	// operation codes
	localparam logic [2:0] OP_FRAME  = 3'd0;
	localparam logic [2:0] OP_UP     = 3'd1;
	localparam logic [2:0] OP_DOWN   = 3'd2;
	localparam logic [2:0] OP_TOGGLE = 3'd3;
	localparam logic [2:0] OP_LOAD   = 3'd4;

	// register indexes
	localparam logic [7:0] REG_CLIP_LEVEL = 8'd0;
	localparam logic [7:0] REG_HOLDOFF    = 8'd1;
	localparam logic [7:0] REG_HOLD       = 8'd2;
	localparam logic [7:0] REG_MAX_GAIN   = 8'd3;

	localparam logic [CLIP_BITS-1:0] CLIP_RESET     = 16'd32767;
	localparam count_t               HOLDOFF_RESET  = 8'd3;
	localparam count_t               HOLD_RESET     = 8'd22;
	localparam gain_t                MAX_GAIN_RESET = 7'd100;
	localparam count_t               AGE_MAX        = 8'hff;

	typedef struct packed {
		logic [2:0] operation;
		sample_t    left_sample;
		sample_t    right_sample;
		logic       last_in_block;
		gain_t      gain_value;
	} in_item_t;

	typedef struct packed {
		mag_t  peak_left;
		mag_t  peak_right;
		mag_t  held_left;
		mag_t  held_right;
		gain_t gain_now;
		logic  auto_on;
		logic  gain_cut;
	} out_item_t;

	typedef struct packed {
		logic [CLIP_BITS-1:0] clip_level;
		count_t               holdoff_blocks;
		count_t               hold_blocks;
		gain_t                max_gain;
	} cfg_t;

	// absolute value; the most negative sample maps onto the sign bit weight
	function automatic mag_t magnitude(sample_t s);
		mag_t u;
		u = mag_t'(s);
		return s[SAMPLE_BITS-1] ? mag_t'(~u + 1'b1) : u;
	endfunction

endpackage

// ----- hdl/spmag_cfg.sv -----
// ---------------------------------------------------------------------------
// spmag_cfg
// Configuration register file, written through a write enable, an index and data.
// ---------------------------------------------------------------------------
module spmag_cfg
	import spmag_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [7:0]           wr_index,
	input  logic [CLIP_BITS-1:0] wr_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.clip_level     <= CLIP_RESET;
			cfg_q.holdoff_blocks <= HOLDOFF_RESET;
			cfg_q.hold_blocks    <= HOLD_RESET;
			cfg_q.max_gain       <= MAX_GAIN_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_CLIP_LEVEL: cfg_q.clip_level     <= wr_data;
				REG_HOLDOFF:    cfg_q.holdoff_blocks <= wr_data[7:0];
				REG_HOLD:       cfg_q.hold_blocks    <= wr_data[7:0];
				REG_MAX_GAIN:   cfg_q.max_gain       <= wr_data[6:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hdl/spmag_meter.sv -----
// ---------------------------------------------------------------------------
// spmag_meter
// Meter state and the single-pass update for one item.
// ---------------------------------------------------------------------------
module spmag_meter
	import spmag_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  in_item_t  item,
	input  cfg_t      cfg,
	output logic      has_result,
	output out_item_t result
);

	mag_t   run_l_q, run_r_q, hold_l_q, hold_r_q;
	count_t age_l_q, age_r_q, holdoff_q;
	gain_t  gain_q;
	logic   auto_q;

	mag_t   run_l_d, run_r_d, hold_l_d, hold_r_d;
	count_t age_l_d, age_r_d, holdoff_d;
	gain_t  gain_d;
	logic   auto_d;

	mag_t   mag_l, mag_r, blk_l, blk_r, hl_t, hr_t;
	count_t al_t, ar_t, hoff_t;
	logic   clip, cut;
	logic [7:0] gain_inc;

	always_comb begin
		run_l_d    = run_l_q;
		run_r_d    = run_r_q;
		hold_l_d   = hold_l_q;
		hold_r_d   = hold_r_q;
		age_l_d    = age_l_q;
		age_r_d    = age_r_q;
		holdoff_d  = holdoff_q;
		gain_d     = gain_q;
		auto_d     = auto_q;
		has_result = 1'b0;
		cut        = 1'b0;

		mag_l = magnitude(item.left_sample);
		mag_r = magnitude(item.right_sample);
		blk_l = (mag_l > run_l_q) ? mag_l : run_l_q;
		blk_r = (mag_r > run_r_q) ? mag_r : run_r_q;

		// age, expire, then recapture the held peaks
		al_t = (age_l_q < AGE_MAX) ? age_l_q + 8'd1 : age_l_q;
		ar_t = (age_r_q < AGE_MAX) ? age_r_q + 8'd1 : age_r_q;
		hl_t = (al_t > cfg.hold_blocks) ? '0 : hold_l_q;
		hr_t = (ar_t > cfg.hold_blocks) ? '0 : hold_r_q;

		hoff_t = (holdoff_q != 8'd0) ? holdoff_q - 8'd1 : holdoff_q;
		clip   = (CMP_BITS'(blk_l) >= CMP_BITS'(cfg.clip_level)) ||
		         (CMP_BITS'(blk_r) >= CMP_BITS'(cfg.clip_level));
		gain_inc = {1'b0, gain_q} + 8'd1;

		unique case (item.operation)
			OP_FRAME: begin
				if (item.last_in_block) begin
					has_result = 1'b1;
					run_l_d    = '0;
					run_r_d    = '0;
					if (hl_t < blk_l) begin
						hold_l_d = blk_l;
						age_l_d  = '0;
					end else begin
						hold_l_d = hl_t;
						age_l_d  = al_t;
					end
					if (hr_t < blk_r) begin
						hold_r_d = blk_r;
						age_r_d  = '0;
					end else begin
						hold_r_d = hr_t;
						age_r_d  = ar_t;
					end
					holdoff_d = hoff_t;
					if (auto_q && hoff_t == 8'd0 && clip) begin
						cut       = 1'b1;
						holdoff_d = cfg.holdoff_blocks;
						if (gain_q != '0)
							gain_d = gain_q - 7'd1;
					end
				end else begin
					run_l_d = blk_l;
					run_r_d = blk_r;
				end
			end
			OP_UP: begin
				has_result = 1'b1;
				gain_d = (gain_inc > {1'b0, cfg.max_gain}) ? cfg.max_gain : gain_inc[6:0];
			end
			OP_DOWN: begin
				has_result = 1'b1;
				if (gain_q != '0)
					gain_d = gain_q - 7'd1;
			end
			OP_TOGGLE: begin
				has_result = 1'b1;
				auto_d     = ~auto_q;
			end
			OP_LOAD: begin
				has_result = 1'b1;
				gain_d     = item.gain_value;
			end
			default: ;
		endcase

		result.peak_left  = (item.operation == OP_FRAME) ? blk_l : '0;
		result.peak_right = (item.operation == OP_FRAME) ? blk_r : '0;
		result.held_left  = hold_l_d;
		result.held_right = hold_r_d;
		result.gain_now   = gain_d;
		result.auto_on    = auto_d;
		result.gain_cut   = cut;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_l_q   <= '0;
			run_r_q   <= '0;
			hold_l_q  <= '0;
			hold_r_q  <= '0;
			age_l_q   <= '0;
			age_r_q   <= '0;
			holdoff_q <= '0;
			gain_q    <= '0;
			auto_q    <= 1'b1;
		end else if (step) begin
			run_l_q   <= run_l_d;
			run_r_q   <= run_r_d;
			hold_l_q  <= hold_l_d;
			hold_r_q  <= hold_r_d;
			age_l_q   <= age_l_d;
			age_r_q   <= age_r_d;
			holdoff_q <= holdoff_d;
			gain_q    <= gain_d;
			auto_q    <= auto_d;
		end
	end

endmodule

// ----- hdl/stereo_peak_meter_auto_gain_core.sv -----
// ---------------------------------------------------------------------------
// stereo_peak_meter_auto_gain_core
// Stereo block peak meter with peak hold and automatic gain reduction.
// ---------------------------------------------------------------------------
// One item is accepted per clock cycle unless a waiting result stalls the
// pipeline. An accepted item sits in the input register while the meter
// state is updated, and its result, if any, is then written to the output
// register, which drives out_valid. The output register stalls the input
// register only while a waiting result is not taken. Frames that do not
// close a block and unused operation codes give no result. Configuration
// writes complete in the cycle they are presented (cfg_ready is always high).
module stereo_peak_meter_auto_gain_core
	import spmag_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [7:0]           cfg_index,
	input  logic [CLIP_BITS-1:0] cfg_data
);

	cfg_t      cfg;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t out_item_q;
	logic      out_valid_q;
	logic      advance, has_result;
	out_item_t result;

	assign cfg_ready = 1'b1;

	spmag_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// advance the input register whenever the output register can take a result
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			item_s1 <= in_data;
	end

	spmag_meter u_meter (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.item       (item_s1),
		.cfg        (cfg),
		.has_result (has_result),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance && has_result)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance && has_result)
			out_item_q <= result;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_item_q;

endmodule

// ----- hdl/spmag_checker.sv -----
// ---------------------------------------------------------------------------
// spmag_checker
// Port-level checks on the stereo peak meter, bound to the top level.
// ---------------------------------------------------------------------------
`include "stereo_peak_meter_auto_gain_core_assert.svh"

module spmag_checker
	import spmag_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	logic stalled;
	logic held_ok;
	logic cut_seen;

	assign stalled  = out_valid && !out_ready;
	assign held_ok  = (out_data.held_left >= out_data.peak_left) &&
	                  (out_data.held_right >= out_data.peak_right);
	assign cut_seen = out_valid && out_data.gain_cut;

	// a waiting result holds until transferred
	`SPMAG_ASSERT_RST(a_out_hold, stalled |=> out_valid && $stable(out_data), "result moved")

	// held peaks never fall below the block peak just reported
	`SPMAG_ASSERT(a_held_ge_peak, clk, arst_n, out_valid |-> held_ok, "held peak below block peak")

	// an automatic cut only happens with auto-adjust on
	`SPMAG_ASSERT_RST(a_cut_needs_auto, cut_seen |-> out_data.auto_on, "cut with auto off")

endmodule

bind stereo_peak_meter_auto_gain_core spmag_checker u_spmag_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
